FILE: rtl/qam16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qam16_pkg
// types, codes and constant tables shared by the 16-qam modulator
// ----------------------------------------------------------------------------
package qam16_pkg;

  localparam int CarrierLen = 12;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SEND  = 2'd1,
    REQ_FRAME = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         tap_index;
    logic signed [15:0] tap_value;
    logic [3:0]         symbol_bits;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MAC,
    ST_MIX,
    ST_RND,
    ST_GAIN,
    ST_OUT
  } state_t;

  // control from sequencer to the datapath
  typedef struct packed {
    logic acc_clr;
    logic acc_en;
    logic mix_en;
    logic gain_en;
  } dp_ctrl_t;

  function automatic logic signed [15:0] level_of(input logic [1:0] code);
    case (code)
      2'd0:    level_of = -16'sd32768;
      2'd1:    level_of = -16'sd10923;
      2'd2:    level_of = 16'sd32767;
      default: level_of = 16'sd10923;
    endcase
  endfunction

  function automatic logic signed [15:0] cos_of(input logic [3:0] ph);
    case (ph)
      4'd0:    cos_of = 16'sd32767;
      4'd1:    cos_of = 16'sd28378;
      4'd2:    cos_of = 16'sd16384;
      4'd3:    cos_of = 16'sd0;
      4'd4:    cos_of = -16'sd16384;
      4'd5:    cos_of = -16'sd28378;
      4'd6:    cos_of = -16'sd32767;
      4'd7:    cos_of = -16'sd28378;
      4'd8:    cos_of = -16'sd16384;
      4'd9:    cos_of = 16'sd0;
      4'd10:   cos_of = 16'sd16384;
      4'd11:   cos_of = 16'sd28378;
      default: cos_of = 16'sd32767;
    endcase
  endfunction

  function automatic logic signed [15:0] sin_of(input logic [3:0] ph);
    case (ph)
      4'd0:    sin_of = 16'sd0;
      4'd1:    sin_of = 16'sd16384;
      4'd2:    sin_of = 16'sd28378;
      4'd3:    sin_of = 16'sd32767;
      4'd4:    sin_of = 16'sd28378;
      4'd5:    sin_of = 16'sd16384;
      4'd6:    sin_of = 16'sd0;
      4'd7:    sin_of = -16'sd16384;
      4'd8:    sin_of = -16'sd28378;
      4'd9:    sin_of = -16'sd32767;
      4'd10:   sin_of = -16'sd28378;
      4'd11:   sin_of = -16'sd16384;
      default: sin_of = 16'sd0;
    endcase
  endfunction

  // round half up by s bits then saturate to 16 bits
  function automatic logic signed [15:0] rnd_sat(input logic signed [47:0] v,
                                                 input int unsigned s);
    logic signed [47:0] r;
    r = (v + (48'sd1 <<< (s - 1))) >>> s;
    if (r > 48'sd32767)       rnd_sat = 16'sd32767;
    else if (r < -48'sd32768) rnd_sat = -16'sd32768;
    else                      rnd_sat = r[15:0];
  endfunction

endpackage

FILE: rtl/qam16_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qam16_mem
// synchronous ram with one write port and one read port, registered read
// ----------------------------------------------------------------------------
module qam16_mem #(
  parameter int Depth = 64,
  parameter int Width = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/qam16_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qam16_dp
// one mac per rail sharing the tap, then carrier mix and gain with rounding
// ----------------------------------------------------------------------------
module qam16_dp (
  input  logic                    clk,
  input  qam16_pkg::dp_ctrl_t     ctrl,
  input  logic signed [15:0]      tap,
  input  logic signed [15:0]      xi,
  input  logic signed [15:0]      xq,
  input  logic [3:0]              phase,
  input  logic [15:0]             gain,
  output logic signed [15:0]      sample
);

  logic signed [47:0] acc_i_r, acc_q_r;
  logic signed [31:0] pi_r, pq_r;
  logic signed [15:0] yi, yq;
  logic signed [31:0] mc_r, ms_r;
  logic signed [15:0] mix;
  logic signed [15:0] mix_r;
  logic signed [32:0] g_prod;
  logic signed [15:0] sample_r;

  assign yi  = qam16_pkg::rnd_sat(acc_i_r, 15);
  assign yq  = qam16_pkg::rnd_sat(acc_q_r, 15);
  assign mix = qam16_pkg::rnd_sat(48'(mc_r) - 48'(ms_r), 15);
  assign g_prod = $signed({{17{mix_r[15]}}, mix_r}) * $signed({17'd0, gain});

  always_ff @(posedge clk) begin
    pi_r <= tap * xi;
    pq_r <= tap * xq;
    if (ctrl.acc_clr) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_i_r <= acc_i_r + 48'(pi_r);
      acc_q_r <= acc_q_r + 48'(pq_r);
    end
    if (ctrl.mix_en) begin
      mc_r <= yi * qam16_pkg::cos_of(phase);
      ms_r <= yq * qam16_pkg::sin_of(phase);
    end
    mix_r <= mix;
    if (ctrl.gain_en) begin
      sample_r <= qam16_pkg::rnd_sat(48'(g_prod), 12);
    end
  end

  assign sample = sample_r;

endmodule

FILE: rtl/qam16_pulse_shaped_modulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qam16_pulse_shaped_modulator
// 16-qam mapper, zero-stuffed upsampler, two fir rails with one mac each,
// carrier mix, gain and saturation
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// in_      in   valid / stall  qam16_pkg::in_item_t
// out_     out  valid / stall  qam16_pkg::out_item_t
// cfg_     in   valid / ready  output_gain, 16 bits
//
// a tap load is written as it is taken; a start frame clears the delay rams
// a symbol yields OVERSAMPLE output samples, and for each of them one mac per
// rail walks TAPS delay-line entries
// after reset the delay rams are cleared before items are taken
// out_stall holds the sample register and the sequencer
// ----------------------------------------------------------------------------
module qam16_pulse_shaped_modulator #(
  parameter int TAPS       = 64,
  parameter int OVERSAMPLE = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  qam16_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output qam16_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);

  localparam int AW = $clog2(TAPS);
  localparam int OW = $clog2(OVERSAMPLE);
  localparam int TW = (TAPS > 64) ? 64 : TAPS;
  localparam int MD = 1 << AW;

  qam16_pkg::state_t state_r, state_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [OW-1:0] n_r, n_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [3:0]    ph_r, ph_nxt;
  logic [15:0]   gain_r;
  logic          out_valid_r, out_valid_nxt;
  logic          last_r, last_nxt;
  logic          accept;
  qam16_pkg::dp_ctrl_t ctrl;

  // ram ports
  logic          tap_we, dl_we;
  logic [AW-1:0] tap_waddr, rd_addr, dl_waddr;
  logic [15:0]   tap_wdata, tap_rd, dli_wdata, dlq_wdata, dli_rd, dlq_rd;
  logic          zero_tap_r;
  logic signed [15:0] tap_eff, xi_eff, xq_eff;
  logic signed [15:0] sample;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != qam16_pkg::ST_IDLE);

  // circular delay line: entry base+k holds line[k]
  assign rd_addr = base_r + cnt_r[AW-1:0];

  assign tap_we    = accept && (in_data.req_type == qam16_pkg::REQ_LOAD)
                     && (7'(in_data.tap_index) < 7'(TW));
  assign tap_waddr = AW'(in_data.tap_index);
  assign tap_wdata = in_data.tap_value;

  qam16_mem #(.Depth(MD), .Width(16)) u_tap (
    .clk, .we(tap_we), .waddr(tap_waddr), .wdata(tap_wdata),
    .raddr(cnt_r[AW-1:0]), .rdata(tap_rd));
  qam16_mem #(.Depth(MD), .Width(16)) u_dli (
    .clk, .we(dl_we), .waddr(dl_waddr), .wdata(dli_wdata),
    .raddr(rd_addr), .rdata(dli_rd));
  qam16_mem #(.Depth(MD), .Width(16)) u_dlq (
    .clk, .we(dl_we), .waddr(dl_waddr), .wdata(dlq_wdata),
    .raddr(rd_addr), .rdata(dlq_rd));

  // taps at index 64 and above cannot be loaded and read as zero
  always_ff @(posedge clk) begin
    zero_tap_r <= ({1'b0, cnt_r} >= (AW + 2)'(TW));
  end
  assign tap_eff = zero_tap_r ? 16'sd0 : $signed(tap_rd);
  assign xi_eff  = $signed(dli_rd);
  assign xq_eff  = $signed(dlq_rd);

  qam16_dp u_dp (
    .clk, .ctrl, .tap(tap_eff), .xi(xi_eff), .xq(xq_eff),
    .phase(ph_r), .gain(gain_r), .sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qam16_pkg::ST_CLEAR;
      cnt_r       <= '0;
      n_r         <= '0;
      base_r      <= '0;
      ph_r        <= '0;
      gain_r      <= 16'd4096;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      base_r      <= base_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      if (cfg_valid && cfg_ready) begin
        gain_r <= cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    base_nxt      = base_r;
    ph_nxt        = ph_r;
    out_valid_nxt = out_valid_r;
    last_nxt      = last_r;
    ctrl          = '0;
    dl_we         = 1'b0;
    dl_waddr      = base_r;
    dli_wdata     = '0;
    dlq_wdata     = '0;
    case (state_r)
      qam16_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            qam16_pkg::REQ_FRAME: begin
              state_nxt = qam16_pkg::ST_CLEAR;
              cnt_nxt   = '0;
              ph_nxt    = '0;
            end
            qam16_pkg::REQ_SEND: begin
              // push the level into the slot that becomes line[0]
              base_nxt  = base_r - AW'(1);
              dl_we     = 1'b1;
              dl_waddr  = base_r - AW'(1);
              dli_wdata = qam16_pkg::level_of(in_data.symbol_bits[3:2]);
              dlq_wdata = qam16_pkg::level_of(in_data.symbol_bits[1:0]);
              n_nxt     = '0;
              cnt_nxt   = '0;
              state_nxt = qam16_pkg::ST_MAC;
            end
            default: ;
          endcase
        end
      end
      qam16_pkg::ST_CLEAR: begin
        dl_we    = 1'b1;
        dl_waddr = cnt_r[AW-1:0];
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == (AW + 1)'(TAPS - 1)) begin
          state_nxt = qam16_pkg::ST_IDLE;
          base_nxt  = '0;
        end
      end
      qam16_pkg::ST_MAC: begin
        // read at cnt into the ram output register, then the product register, then the accumulator
        if (cnt_r == '0) ctrl.acc_clr = 1'b1;
        if (cnt_r >= (AW + 1)'(2)) ctrl.acc_en = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW + 1)'(TAPS + 1)) begin
          state_nxt = qam16_pkg::ST_MIX;
        end
      end
      qam16_pkg::ST_MIX: begin
        ctrl.mix_en = 1'b1;
        state_nxt   = qam16_pkg::ST_RND;
      end
      qam16_pkg::ST_RND: begin
        // mix products rounded into mix_r
        state_nxt = qam16_pkg::ST_GAIN;
      end
      qam16_pkg::ST_GAIN: begin
        // mix_r registered last cycle; gain into sample register unless a stalled sample is held
        if (!out_valid_r || !out_stall) begin
          ctrl.gain_en = 1'b1;
          state_nxt    = qam16_pkg::ST_OUT;
        end
      end
      qam16_pkg::ST_OUT: begin
        out_valid_nxt = 1'b1;
        last_nxt      = (n_r == OW'(OVERSAMPLE - 1));
        ph_nxt        = (ph_r == 4'(qam16_pkg::CarrierLen - 1)) ? 4'd0 : ph_r + 4'd1;
        cnt_nxt       = '0;
        if (n_r == OW'(OVERSAMPLE - 1)) begin
          state_nxt = qam16_pkg::ST_IDLE;
        end else begin
          n_nxt     = n_r + OW'(1);
          base_nxt  = base_r - AW'(1);
          dl_we     = 1'b1;
          dl_waddr  = base_r - AW'(1);
          state_nxt = qam16_pkg::ST_MAC;
        end
      end
      default: state_nxt = qam16_pkg::ST_IDLE;
    endcase
    if (out_valid_r && !out_stall && !(state_r == qam16_pkg::ST_OUT)) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data.sample      = sample;
  assign out_data.last_sample = last_r;

`ifndef NO_ASSERTIONS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != qam16_pkg::ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled sample changed");
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r < 4'(qam16_pkg::CarrierLen))
    else $error("carrier phase out of range");
`endif

endmodule

FILE: tb/tb_qam16_pulse_shaped_modulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qam16_pulse_shaped_modulator
// drives tap loads, symbols and frame starts with random gaps and output
// stalls, predicts every passband sample and checks it in order, stepping
// the output gain through its extremes between phases
// ----------------------------------------------------------------------------
module tb_qam16_pulse_shaped_modulator;

  localparam int NTAPS    = 64;
  localparam int OVS      = 8;
  localparam int SETTLE   = 300;
  localparam int WD_LIMIT = 20000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  qam16_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  qam16_pkg::out_item_t out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [15:0]          cfg_data;

  qam16_pulse_shaped_modulator #(.TAPS(NTAPS), .OVERSAMPLE(OVS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  typedef struct {
    qam16_pkg::in_item_t item;
    bit                  zero_out;
  } stim_row_t;

  // shaping state
  longint     coef[NTAPS];
  longint     line_i[NTAPS];
  longint     line_q[NTAPS];
  int         phase;
  longint     gain;
  qam16_pkg::out_item_t expected_samples[$];
  int         errors;
  int         idle_cycles;
  int         stall_left;
  bit         gaps_on;
  bit         stalls_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_sat(longint v, int s);
    longint r;
    r = (v + (longint'(1) << (s - 1))) >>> s;
    if (r > 32767) return 32767;
    if (r < -32768) return -32768;
    return r;
  endfunction

  function automatic longint level_for(logic [1:0] code);
    case (code)
      2'd0:    return -32768;
      2'd1:    return -10923;
      2'd2:    return 32767;
      default: return 10923;
    endcase
  endfunction

  function automatic longint carrier_cos(int ph);
    longint t[12] = '{32767, 28378, 16384, 0, -16384, -28378,
                      -32767, -28378, -16384, 0, 16384, 28378};
    return t[ph];
  endfunction

  function automatic longint carrier_sin(int ph);
    longint t[12] = '{0, 16384, 28378, 32767, 28378, 16384,
                      0, -16384, -28378, -32767, -28378, -16384};
    return t[ph];
  endfunction

  function automatic longint shape_rail(ref longint ln[NTAPS], input longint x);
    longint acc;
    acc = 0;
    for (int i = NTAPS - 1; i > 0; i--) ln[i] = ln[i - 1];
    ln[0] = x;
    for (int i = 0; i < NTAPS; i++) acc += coef[i] * ln[i];
    return round_sat(acc, 15);
  endfunction

  // updates the shaping state and queues the samples a request yields
  task automatic modulate_item(qam16_pkg::in_item_t it, bit zero_out);
    longint yi, yq, mix, s, g;
    qam16_pkg::out_item_t o;
    case (qam16_pkg::req_t'(it.req_type))
      qam16_pkg::REQ_LOAD: coef[it.tap_index] = longint'(it.tap_value);
      qam16_pkg::REQ_FRAME: begin
        foreach (line_i[k]) begin
          line_i[k] = 0;
          line_q[k] = 0;
        end
        phase = 0;
      end
      qam16_pkg::REQ_SEND: begin
        for (int n = 0; n < OVS; n++) begin
          yi = shape_rail(line_i, n == 0 ? level_for(it.symbol_bits[3:2]) : 0);
          yq = shape_rail(line_q, n == 0 ? level_for(it.symbol_bits[1:0]) : 0);
          mix = yi * carrier_cos(phase) - yq * carrier_sin(phase);
          s = round_sat(mix, 15);
          g = round_sat(s * gain, 12);
          o.sample = zero_out ? 16'sd0 : 16'(g);
          o.last_sample = (n == OVS - 1);
          expected_samples.push_back(o);
          phase = (phase + 1) % 12;
        end
      end
      default: ;
    endcase
  endtask

  task automatic drive_item(qam16_pkg::in_item_t it, bit zero_out);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    modulate_item(it, zero_out);
  endtask

  task automatic write_gain(logic [15:0] v);
    @(negedge clk);
    in_valid  = 1'b0;
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    gain = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic qam16_pkg::in_item_t load_of(int idx, int v);
    qam16_pkg::in_item_t it;
    it = '0;
    it.req_type  = qam16_pkg::REQ_LOAD;
    it.tap_index = 6'(idx);
    it.tap_value = 16'(v);
    it.symbol_bits = 4'($urandom);
    return it;
  endfunction

  function automatic qam16_pkg::in_item_t send_of(int sym);
    qam16_pkg::in_item_t it;
    it = qam16_pkg::in_item_t'($urandom);
    it.req_type    = qam16_pkg::REQ_SEND;
    it.symbol_bits = 4'(sym);
    return it;
  endfunction

  function automatic qam16_pkg::in_item_t ctl_of(qam16_pkg::req_t r);
    qam16_pkg::in_item_t it;
    it = qam16_pkg::in_item_t'($urandom);
    it.req_type = r;
    return it;
  endfunction

  function automatic qam16_pkg::in_item_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return send_of($urandom_range(0, 15));
    if (pick < 85) begin
      case ($urandom_range(0, 3))
        0:       return load_of($urandom_range(0, 63), 32767);
        1:       return load_of($urandom_range(0, 63), -32768);
        default: return load_of($urandom_range(0, 63), $urandom_range(0, 65535) - 32768);
      endcase
    end
    if (pick < 93) return ctl_of(qam16_pkg::REQ_FRAME);
    return ctl_of(qam16_pkg::REQ_NONE);
  endfunction

  // output side: stall count drawn per item
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    qam16_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $error("sample: no item expected, actual %0d", out_data.sample);
        errors++;
      end else begin
        e = expected_samples.pop_front();
        if (out_data.sample !== e.sample) begin
          $error("sample: expected %0d, actual %0d", e.sample, out_data.sample);
          errors++;
        end
        if (out_data.last_sample !== e.last_sample) begin
          $error("last_sample: expected %0d, actual %0d", e.last_sample,
                 out_data.last_sample);
          errors++;
        end
      end
      stall_left <= stalls_on ? $urandom_range(0, 16) : 0;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    logic [15:0] gains[6] = '{16'd0, 16'd65535, 16'd1, 16'd4096, 16'd0, 16'd0};
    int syms[16] = '{0, 5, 10, 15, 2, 7, 8, 13, 3, 12, 6, 9, 11, 14, 1, 4};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_stall = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    errors = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    gain = 4096;
    phase = 0;
    foreach (coef[k]) begin
      coef[k] = 0;
      line_i[k] = 0;
      line_q[k] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every tap written before the first symbol
    for (int k = 0; k < NTAPS; k++) drive_item(load_of(k, 0), 1'b0);

    rows.push_back('{send_of(0), 1'b1});
    rows.push_back('{send_of(15), 1'b1});
    rows.push_back('{load_of(0, 32767), 1'b0});
    rows.push_back('{load_of(63, -32768), 1'b0});
    rows.push_back('{load_of(1, -32768), 1'b0});
    rows.push_back('{load_of(5, 16384), 1'b0});
    for (int k = 0; k < 8; k++) rows.push_back('{send_of(syms[k]), 1'b0});
    rows.push_back('{ctl_of(qam16_pkg::REQ_FRAME), 1'b0});
    rows.push_back('{ctl_of(qam16_pkg::REQ_NONE), 1'b0});
    for (int k = 8; k < 10; k++) rows.push_back('{send_of(syms[k]), 1'b0});
    rows.push_back('{ctl_of(qam16_pkg::REQ_FRAME), 1'b0});
    for (int k = 10; k < 16; k++) rows.push_back('{send_of(syms[k]), 1'b0});
    foreach (rows[r]) drive_item(rows[r].item, rows[r].zero_out);

    gains[4] = 16'($urandom);
    gains[5] = 16'($urandom_range(2048, 8192));
    foreach (gains[p]) begin
      @(negedge clk);
      in_valid = 1'b0;
      while (expected_samples.size() != 0) @(posedge clk);
      write_gain(gains[p]);
      gaps_on = (p % 3) != 1;
      stalls_on = (p % 3) != 2;
      for (int k = 0; k < 70; k++) drive_item(random_item(), 1'b0);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
